// ===== rtl/core/bvfp_pkg.sv =====
`default_nettype none

package bvfp_pkg;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int IDX_PORT_W = 16;
    localparam int IDENT_W    = 15;
    localparam int LEN_W      = 22;
    localparam int OFF_W      = 16;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;

    // parameter defaults
    localparam int INDEX_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DESC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

    // stop status codes
    localparam logic [STATUS_W-1:0] STAT_CLEAN     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_END_MARK  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_TRUNCATED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_SIZE  = 2'd3;

    // one result transaction
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [IDENT_W-1:0]  ident;
        logic [LEN_W-1:0]    length;
        logic [OFF_W-1:0]    offset;
        logic [BYTE_W-1:0]   data;
        logic                last;
        logic [STATUS_W-1:0] status;
    } result_t;

    // queue entry: a result, optionally followed by a clean-finish report
    typedef struct packed {
        result_t res;
        logic    fin_after;
    } entry_t;

    // stop report with all other fields cleared
    function automatic result_t stop_result(input logic [STATUS_W-1:0] status);
        result_t r;
        r        = '0;
        r.kind   = KIND_STOP;
        r.status = status;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bvfp_byte_if.sv =====
`default_nettype none

interface bvfp_byte_if
    import bvfp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [BYTE_W-1:0]     rec_byte;
    logic [IDX_PORT_W-1:0] byte_index;
    logic                  record_start;

    modport source (output valid, output rec_byte, output byte_index,
                    output record_start, input ready);
    modport sink   (input valid, input rec_byte, input byte_index,
                    input record_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bvfp_result_if.sv =====
`default_nettype none

interface bvfp_result_if
    import bvfp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   result_kind;
    logic [IDENT_W-1:0]  field_ident;
    logic [LEN_W-1:0]    field_length;
    logic [OFF_W-1:0]    field_offset;
    logic [BYTE_W-1:0]   data_value;
    logic                last_of_field;
    logic [STATUS_W-1:0] stop_status;

    modport source (output valid, output result_kind, output field_ident,
                    output field_length, output field_offset, output data_value,
                    output last_of_field, output stop_status, input ready);
    modport sink   (input valid, input result_kind, input field_ident,
                    input field_length, input field_offset, input data_value,
                    input last_of_field, input stop_status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/backward_varint_field_parser.sv =====
`default_nettype none

// channel      dir   handshake        payload
// byte_in      in    valid / ready    rec_byte, byte_index, record_start
// result_out   out   valid / ready    result_kind, field_ident, field_length,
//                                     field_offset, data_value, last_of_field,
//                                     stop_status
// cfg          in    cfg_wr_en        cfg_wr_data (fixed_area_size)
//
// one input byte per cycle while the entry queue has room; the header state
// machine decodes each byte in the cycle it is accepted and queues at most one entry
// the result register issues one transaction per cycle while result_out.ready is
// high, so a byte that also closes the record (data or descriptor plus clean
// finish) yields two transactions; results pass the entry queue and then the result
// register; the entry queue of QUEUE_DEPTH entries lets the input run on while the output is stalled
// reset clears the parse state (idle until record_start) and sets fixed_area_size to 0

module backward_varint_field_parser
    import bvfp_pkg::*;
#(
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    bvfp_byte_if.sink       byte_in,
    bvfp_result_if.source   result_out
);

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_entry;

    // header decode and field tracking
    bvfp_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_in     (byte_in),
        .push_valid  (push_valid),
        .push_entry  (push_entry),
        .push_ready  (push_ready)
    );

    // entry queue between decode and result issue
    bvfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    // result issue
    bvfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bvfp_front.sv =====
`default_nettype none

module bvfp_front
    import bvfp_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    bvfp_byte_if.sink        byte_in,
    output logic             push_valid,
    output entry_t           push_entry,
    input  wire logic        push_ready
);

    // index bits that take part in the parse
    localparam int IDX_W = (INDEX_BITS < IDX_PORT_W) ? INDEX_BITS : IDX_PORT_W;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ID1  = 3'd1;
    localparam logic [2:0] PH_ID2  = 3'd2;
    localparam logic [2:0] PH_SZ1  = 3'd3;
    localparam logic [2:0] PH_SZ2  = 3'd4;
    localparam logic [2:0] PH_SZ3  = 3'd5;
    localparam logic [2:0] PH_DATA = 3'd6;
    localparam logic [2:0] PH_DONE = 3'd7;

    logic [7:0]         fixed_area_size_reg;
    logic [2:0]         phase_reg, phase_next;
    logic [IDENT_W-1:0] ident_reg, ident_next;
    logic [LEN_W-1:0]   size_reg, size_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic [OFF_W-1:0]   offset_reg, offset_next;

    logic               fire;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   fixed_i;
    logic               below;
    logic               more_left;
    logic [BYTE_W-1:0]  b;
    logic [2:0]         ph_eff;
    logic [IDENT_W-1:0] ident_eff;
    logic [LEN_W-1:0]   size_eff;
    logic [LEN_W-1:0]   remain_eff;
    logic [LEN_W-1:0]   sz_new;
    logic [LEN_W:0]     diff;
    logic               bad_size;
    logic [OFF_W-1:0]   off_new;
    logic               push_comb;
    entry_t             entry_comb;

    assign fire           = byte_in.valid && byte_in.ready;
    assign byte_in.ready  = push_ready;
    assign push_valid     = fire && push_comb;
    assign push_entry     = entry_comb;

    // input classification
    assign idx        = IDX_W'(byte_in.byte_index);
    assign fixed_i    = IDX_W'(fixed_area_size_reg);
    assign below      = idx < fixed_i;
    assign more_left  = idx > fixed_i;
    assign b          = byte_in.rec_byte;

    // a record start restarts the parse with this byte
    assign ph_eff     = byte_in.record_start ? PH_ID1 : phase_reg;
    assign ident_eff  = byte_in.record_start ? '0 : ident_reg;
    assign size_eff   = byte_in.record_start ? '0 : size_reg;
    assign remain_eff = byte_in.record_start ? '0 : remain_reg;

    // size value as completed by this byte
    always_comb
    begin
        case (ph_eff)
            PH_SZ1:  sz_new = LEN_W'(b);
            PH_SZ2:  sz_new = LEN_W'({b, size_eff[6:0]});
            PH_SZ3:  sz_new = {b, size_eff[13:0]};
            default: sz_new = size_eff;
        endcase
    end

    // size check against the last header byte index
    assign diff     = (LEN_W+1)'(idx) - {1'b0, sz_new};
    assign bad_size = diff[LEN_W] || (diff[LEN_W-1:0] < LEN_W'(fixed_area_size_reg));
    assign off_new  = OFF_W'(diff);

    // parse state machine
    always_comb
    begin
        phase_next  = ph_eff;
        ident_next  = ident_eff;
        size_next   = size_eff;
        remain_next = remain_eff;
        offset_next = byte_in.record_start ? '0 : offset_reg;
        push_comb   = 1'b0;
        entry_comb  = '0;

        if (byte_in.record_start && below)
        begin
            push_comb      = 1'b1;
            entry_comb.res = stop_result(STAT_CLEAN);
            phase_next     = PH_DONE;
        end
        else if (!below)
        begin
            case (ph_eff)
                PH_ID1:
                begin
                    ident_next = IDENT_W'(b);
                    if (b == '0)
                    begin
                        push_comb      = 1'b1;
                        entry_comb.res = stop_result(STAT_END_MARK);
                        phase_next     = PH_DONE;
                    end
                    else if (!more_left)
                    begin
                        push_comb      = 1'b1;
                        entry_comb.res = stop_result(STAT_TRUNCATED);
                        phase_next     = PH_DONE;
                    end
                    else
                    begin
                        phase_next = b[7] ? PH_ID2 : PH_SZ1;
                    end
                end
                PH_ID2:
                begin
                    ident_next = {b, ident_eff[6:0]};
                    if (!more_left)
                    begin
                        push_comb      = 1'b1;
                        entry_comb.res = stop_result(STAT_TRUNCATED);
                        phase_next     = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_SZ1;
                    end
                end
                PH_SZ1, PH_SZ2, PH_SZ3:
                begin
                    size_next = sz_new;
                    if ((ph_eff == PH_SZ3) || ((ph_eff == PH_SZ1) && !b[7])
                        || ((ph_eff == PH_SZ2) && (b == '0)))
                    begin
                        // header complete
                        push_comb = 1'b1;
                        if (bad_size)
                        begin
                            entry_comb.res = stop_result(STAT_BAD_SIZE);
                            phase_next     = PH_DONE;
                        end
                        else
                        begin
                            entry_comb.res.kind   = KIND_DESC;
                            entry_comb.res.ident  = ident_eff;
                            entry_comb.res.length = sz_new;
                            entry_comb.res.offset = off_new;
                            offset_next           = off_new;
                            if (sz_new == '0)
                            begin
                                if (!more_left)
                                begin
                                    entry_comb.fin_after = 1'b1;
                                    phase_next           = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_ID1;
                                end
                            end
                            else
                            begin
                                remain_next = sz_new;
                                phase_next  = PH_DATA;
                            end
                        end
                    end
                    else if (!more_left)
                    begin
                        push_comb      = 1'b1;
                        entry_comb.res = stop_result(STAT_TRUNCATED);
                        phase_next     = PH_DONE;
                    end
                    else
                    begin
                        phase_next = (ph_eff == PH_SZ1) ? PH_SZ2 : PH_SZ3;
                    end
                end
                PH_DATA:
                begin
                    if (remain_eff != '0)
                    begin
                        remain_next = remain_eff - LEN_W'(1);
                    end
                    push_comb             = 1'b1;
                    entry_comb.res.kind   = KIND_DATA;
                    entry_comb.res.ident  = ident_eff;
                    entry_comb.res.length = size_eff;
                    entry_comb.res.offset = offset_reg;
                    entry_comb.res.data   = b;
                    entry_comb.res.last   = (remain_eff <= LEN_W'(1));
                    if (remain_eff <= LEN_W'(1))
                    begin
                        if (!more_left)
                        begin
                            entry_comb.fin_after = 1'b1;
                            phase_next           = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_ID1;
                        end
                    end
                end
                default:
                begin
                    // idle or finished: byte ignored
                    phase_next = ph_eff;
                end
            endcase
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_area_size_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            fixed_area_size_reg <= cfg_wr_data;
        end
    end

    // parse state update on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            ident_reg  <= '0;
            size_reg   <= '0;
            remain_reg <= '0;
            offset_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            ident_reg  <= ident_next;
            size_reg   <= size_next;
            remain_reg <= remain_next;
            offset_reg <= offset_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bvfp_queue.sv =====
`default_nettype none

module bvfp_queue
    import bvfp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    input  wire entry_t push_entry,
    output logic        push_ready,
    output logic        pop_valid,
    output entry_t      pop_entry,
    input  wire logic   pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = cnt_reg != CNT_W'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bvfp_back.sv =====
`default_nettype none

module bvfp_back
    import bvfp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     pop_valid,
    input  wire entry_t   pop_entry,
    output logic          pop_ready,
    bvfp_result_if.source result_out
);

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;
    logic    pend_reg, pend_next;
    logic    load;

    assign load      = !out_valid_reg || result_out.ready;
    assign pop_ready = load && !pend_reg;

    // output register selection
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        pend_next      = pend_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                // clean-finish report that trails a final field transaction
                out_valid_next = 1'b1;
                out_res_next   = stop_result(STAT_CLEAN);
                pend_next      = 1'b0;
            end
            else if (pop_valid)
            begin
                out_valid_next = 1'b1;
                out_res_next   = pop_entry.res;
                pend_next      = pop_entry.fin_after;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    // result channel
    assign result_out.valid         = out_valid_reg;
    assign result_out.result_kind   = out_res_reg.kind;
    assign result_out.field_ident   = out_res_reg.ident;
    assign result_out.field_length  = out_res_reg.length;
    assign result_out.field_offset  = out_res_reg.offset;
    assign result_out.data_value    = out_res_reg.data;
    assign result_out.last_of_field = out_res_reg.last;
    assign result_out.stop_status   = out_res_reg.status;

endmodule

`default_nettype wire
